[rtl/snoise_pkg.sv]
package snoise_pkg;

  // request codes
  typedef enum logic [1:0] {
    REQ_LOAD    = 2'd0,
    REQ_EVAL_1D = 2'd1,
    REQ_EVAL_2D = 2'd2
  } req_t;

  localparam int COORD_FRAC_BITS_DEF = 16;
  localparam int QB    = 30;  // internal fraction bits
  localparam int NLANE = 3;   // simplex corners

  // skew / unskew factors, Q30
  localparam logic signed [29:0] F2_Q30   = 30'sd393016784;
  localparam logic signed [32:0] G2_Q30   = 33'sd226908346;
  localparam logic signed [32:0] ONE_Q30  = 33'sd1073741824;
  localparam logic signed [34:0] HALF_Q30 = 35'sd536870912;

  // output scale, Q16
  localparam logic signed [22:0] K1D_Q16 = 23'sd25887;
  localparam logic signed [22:0] K2D_Q16 = 23'sd2964236;

  // output saturation bound, plus or minus one in Q16
  localparam logic signed [17:0] OUT_MAX = 18'sd65536;

endpackage

[rtl/simplex_noise_1d_2d_core.sv]
// Simplex gradient noise, 1D and 2D, with a loadable 256-byte permutation table.
// Input channel (in_valid/in_ready): one beat is a request. REQ_LOAD writes
// in_table_value into table entry in_table_index and gives no result.
// REQ_EVAL_1D uses in_coord_x, REQ_EVAL_2D uses in_coord_x and in_coord_y
// (signed, COORD_FRAC_BITS fraction bits); each gives one result beat.
// Request code 3 is dropped. Load every table entry before evaluating.
// Output channel (out_valid/out_ready): out_noise_value, signed Q1.16,
// saturated to plus or minus 1.0.
// Throughput: one beat per clock unless the output stalls. The datapath
// is a 12-stage pipeline whose stage 12 register drives the output.
// Table lookups go through three copies of the table, written in order as a
// load passes the stage that reads that copy, so loads and evaluations keep
// their order.
// Reset clears all stage valid bits; the table contents are kept as is.
// When the receiver stalls, each stage holds only while the next is full,
// so bubbles close up and in_ready drops only once the whole pipe is full.
module simplex_noise_1d_2d_core #(
  parameter int COORD_FRAC_BITS = snoise_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  snoise_pkg::req_t        in_req_type,
  input  logic [7:0]              in_table_index,
  input  logic [7:0]              in_table_value,
  input  logic signed [31:0]      in_coord_x,
  input  logic signed [31:0]      in_coord_y,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [17:0]      out_noise_value
);
  import snoise_pkg::*;

  localparam int FB  = COORD_FRAC_BITS;
  localparam int SKW = FB + QB;
  localparam int PW  = 72;

  // round a product with QB fraction bits, halves away from zero
  function automatic logic signed [PW-1:0] rnd_q30(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] adj;
    adj = p + (PW'(1) << (QB - 1)) - {{(PW-1){1'b0}}, p[PW-1]};
    rnd_q30 = adj >>> QB;
  endfunction

  // stage valid bits and ready chain
  logic [12:1] vld_r;
  logic [12:1] rdy;

  always_comb begin
    rdy[12] = !vld_r[12] || out_ready;
    for (int k = 11; k >= 1; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign in_ready = rdy[1];

  logic ev4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[1]) begin
        vld_r[1] <= in_valid && (in_req_type == REQ_LOAD || in_req_type == REQ_EVAL_1D ||
                                 in_req_type == REQ_EVAL_2D);
      end
      for (int k = 2; k <= 12; k++) begin
        if (rdy[k]) begin
          // loads retire after the last table stage
          if (k == 5) begin
            vld_r[k] <= vld_r[k-1] && ev4_r;
          end else begin
            vld_r[k] <= vld_r[k-1];
          end
        end
      end
    end
  end

  // stage 1: capture, skew product (x+y)*F2
  req_t               typ1_r;
  logic [7:0]         idx1_r, val1_r;
  logic signed [31:0] x1_r, y1_r;
  logic signed [62:0] s1_r;
  logic signed [32:0] sum_xy;

  assign sum_xy = 33'(in_coord_x) + 33'(in_coord_y);

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      typ1_r <= in_req_type;
      idx1_r <= in_table_index;
      val1_r <= in_table_value;
      x1_r   <= in_coord_x;
      y1_r   <= in_coord_y;
      s1_r   <= sum_xy * F2_Q30;
    end
  end

  // stage 2: skewed coordinates, cell index and fraction
  req_t               typ2_r;
  logic [7:0]         idx2_r, val2_r;
  logic [QB-1:0]      fx2_r, fy2_r;
  logic [7:0]         ii2_r, jj2_r;
  logic signed [63:0] xs, ys;
  logic [QB-1:0]      fx_nxt, fy_nxt;
  logic [7:0]         ii_nxt, jj_nxt;

  always_comb begin
    xs = {{2{x1_r[31]}}, x1_r, {QB{1'b0}}} + 64'(s1_r);
    ys = {{2{y1_r[31]}}, y1_r, {QB{1'b0}}} + 64'(s1_r);
    if (typ1_r == REQ_EVAL_2D) begin
      fx_nxt = xs[SKW-1:FB];
      fy_nxt = ys[SKW-1:FB];
      ii_nxt = xs[SKW+7:SKW];
      jj_nxt = ys[SKW+7:SKW];
    end else begin
      fx_nxt = {x1_r[FB-1:0], {(QB-FB){1'b0}}};
      fy_nxt = '0;
      ii_nxt = x1_r[FB+7:FB];
      jj_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      typ2_r <= typ1_r;
      idx2_r <= idx1_r;
      val2_r <= val1_r;
      fx2_r  <= fx_nxt;
      fy2_r  <= fy_nxt;
      ii2_r  <= ii_nxt;
      jj2_r  <= jj_nxt;
    end
  end

  // stage 3: first table level on j, unskew offset, triangle choice
  logic [7:0]         mem_a [256];
  req_t               typ3_r;
  logic [7:0]         idx3_r, val3_r;
  logic [QB-1:0]      fx3_r, fy3_r, tg3_r;
  logic [7:0]         ii3_r, pa0_r, pa1_r;
  logic               i1_3_r;
  logic [QB:0]        sxy;
  logic signed [64:0] gprod;
  logic signed [PW-1:0] g_rnd;

  always_comb begin
    sxy   = {1'b0, fx2_r} + {1'b0, fy2_r};
    gprod = $signed({1'b0, sxy}) * G2_Q30;
    g_rnd = rnd_q30(PW'(gprod));
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      if (vld_r[2] && typ2_r == REQ_LOAD) begin
        mem_a[idx2_r] <= val2_r;
      end
      pa0_r  <= mem_a[jj2_r];
      pa1_r  <= mem_a[jj2_r + 8'd1];
      typ3_r <= typ2_r;
      idx3_r <= idx2_r;
      val3_r <= val2_r;
      fx3_r  <= fx2_r;
      fy3_r  <= fy2_r;
      ii3_r  <= ii2_r;
      i1_3_r <= fx2_r > fy2_r;
      tg3_r  <= g_rnd[QB-1:0];
    end
  end

  // stage 4: corner offsets, second table level gives corner hashes
  logic [7:0]         mem_b [256];
  logic [7:0]         mem_c [256];
  logic signed [32:0] lx4_r [NLANE];
  logic signed [32:0] ly4_r [NLANE];
  logic [7:0]         h4_r  [NLANE];
  logic               m2d4_r;
  logic signed [32:0] lx_nxt [NLANE];
  logic signed [32:0] ly_nxt [NLANE];
  logic signed [32:0] ex, ey, x0, y0;
  logic [7:0]         b0, b1, b2;

  always_comb begin
    ex = $signed({3'b0, fx3_r});
    ey = $signed({3'b0, fy3_r});
    x0 = ex - $signed({3'b0, tg3_r});
    y0 = ey - $signed({3'b0, tg3_r});
    if (typ3_r == REQ_EVAL_2D) begin
      lx_nxt[0] = x0;
      ly_nxt[0] = y0;
      lx_nxt[1] = x0 - (i1_3_r ? ONE_Q30 : 33'sd0) + G2_Q30;
      ly_nxt[1] = y0 - (i1_3_r ? 33'sd0 : ONE_Q30) + G2_Q30;
      lx_nxt[2] = x0 - ONE_Q30 + G2_Q30 + G2_Q30;
      ly_nxt[2] = y0 - ONE_Q30 + G2_Q30 + G2_Q30;
      b0 = ii3_r + pa0_r;
      b1 = ii3_r + {7'b0, i1_3_r} + (i1_3_r ? pa0_r : pa1_r);
      b2 = ii3_r + 8'd1 + pa1_r;
    end else begin
      lx_nxt[0] = ex;
      ly_nxt[0] = '0;
      lx_nxt[1] = ex - ONE_Q30;
      ly_nxt[1] = '0;
      lx_nxt[2] = '0;
      ly_nxt[2] = '0;
      b0 = ii3_r;
      b1 = ii3_r + 8'd1;
      b2 = ii3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      if (vld_r[3] && typ3_r == REQ_LOAD) begin
        mem_b[idx3_r] <= val3_r;
        mem_c[idx3_r] <= val3_r;
      end
      h4_r[0] <= mem_b[b0];
      h4_r[1] <= mem_b[b1];
      h4_r[2] <= mem_c[b2];
      for (int l = 0; l < NLANE; l++) begin
        lx4_r[l] <= lx_nxt[l];
        ly4_r[l] <= ly_nxt[l];
      end
      m2d4_r <= typ3_r == REQ_EVAL_2D;
      ev4_r  <= typ3_r != REQ_LOAD;
    end
  end

  // stage 5: squared distances, gradient dot product
  logic [31:0]        sqx5_r [NLANE];
  logic [31:0]        sqy5_r [NLANE];
  logic signed [35:0] g5_r   [NLANE];
  logic [3:0]         hk5_r  [NLANE];
  logic               hn5_r  [NLANE];
  logic               m2d5_r;
  logic signed [PW-1:0] sqx_rnd [NLANE];
  logic signed [PW-1:0] sqy_rnd [NLANE];
  logic signed [35:0] g_nxt  [NLANE];
  logic signed [33:0] gu;
  logic signed [34:0] gv;
  logic signed [32:0] uu, vv;

  always_comb begin
    gu = '0;
    gv = '0;
    uu = '0;
    vv = '0;
    for (int l = 0; l < NLANE; l++) begin
      sqx_rnd[l] = rnd_q30(PW'(lx4_r[l] * lx4_r[l]));
      sqy_rnd[l] = rnd_q30(PW'(ly4_r[l] * ly4_r[l]));
      uu = h4_r[l][2] ? ly4_r[l] : lx4_r[l];
      vv = h4_r[l][2] ? lx4_r[l] : ly4_r[l];
      gu = h4_r[l][0] ? -34'(uu) : 34'(uu);
      gv = h4_r[l][1] ? -(35'(vv) <<< 1) : (35'(vv) <<< 1);
      if (m2d4_r) begin
        g_nxt[l] = 36'(gu) + 36'(gv);
      end else begin
        g_nxt[l] = 36'(lx4_r[l]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      for (int l = 0; l < NLANE; l++) begin
        sqx5_r[l] <= sqx_rnd[l][31:0];
        sqy5_r[l] <= sqy_rnd[l][31:0];
        g5_r[l]   <= g_nxt[l];
        hk5_r[l]  <= {1'b0, h4_r[l][2:0]} + 4'd1;
        hn5_r[l]  <= h4_r[l][3];
      end
      m2d5_r <= m2d4_r;
    end
  end

  // stage 6: falloff, clamped at zero
  logic [30:0]        t6_r  [NLANE];
  logic signed [35:0] g6_r  [NLANE];
  logic [3:0]         hk6_r [NLANE];
  logic               hn6_r [NLANE];
  logic               m2d6_r;
  logic signed [34:0] tt    [NLANE];

  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      tt[l] = (m2d5_r ? HALF_Q30 : 35'(ONE_Q30)) - $signed({3'b0, sqx5_r[l]})
              - $signed({3'b0, sqy5_r[l]});
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      for (int l = 0; l < NLANE; l++) begin
        t6_r[l]  <= tt[l][34] ? 31'd0 : tt[l][30:0];
        g6_r[l]  <= g5_r[l];
        hk6_r[l] <= hk5_r[l];
        hn6_r[l] <= hn5_r[l];
      end
      m2d6_r <= m2d5_r;
    end
  end

  // stage 7: t^2
  logic [30:0]        t7_r  [NLANE];
  logic signed [35:0] g7_r  [NLANE];
  logic [3:0]         hk7_r [NLANE];
  logic               hn7_r [NLANE];
  logic               m2d7_r;
  logic signed [PW-1:0] t7_rnd [NLANE];

  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      t7_rnd[l] = rnd_q30(PW'($signed({1'b0, t6_r[l]}) * $signed({1'b0, t6_r[l]})));
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      for (int l = 0; l < NLANE; l++) begin
        t7_r[l]  <= t7_rnd[l][30:0];
        g7_r[l]  <= g6_r[l];
        hk7_r[l] <= hk6_r[l];
        hn7_r[l] <= hn6_r[l];
      end
      m2d7_r <= m2d6_r;
    end
  end

  // stage 8: t^4
  logic [30:0]        t8_r  [NLANE];
  logic signed [35:0] g8_r  [NLANE];
  logic [3:0]         hk8_r [NLANE];
  logic               hn8_r [NLANE];
  logic               m2d8_r;
  logic signed [PW-1:0] t8_rnd [NLANE];

  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      t8_rnd[l] = rnd_q30(PW'($signed({1'b0, t7_r[l]}) * $signed({1'b0, t7_r[l]})));
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[8]) begin
      for (int l = 0; l < NLANE; l++) begin
        t8_r[l]  <= t8_rnd[l][30:0];
        g8_r[l]  <= g7_r[l];
        hk8_r[l] <= hk7_r[l];
        hn8_r[l] <= hn7_r[l];
      end
      m2d8_r <= m2d7_r;
    end
  end

  // stage 9: weighted gradient term
  logic signed [35:0] p9_r  [NLANE];
  logic [3:0]         hk9_r [NLANE];
  logic               hn9_r [NLANE];
  logic               m2d9_r;
  logic signed [PW-1:0] p_rnd [NLANE];

  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      p_rnd[l] = rnd_q30(PW'($signed({1'b0, t8_r[l]}) * g8_r[l]));
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[9]) begin
      for (int l = 0; l < NLANE; l++) begin
        p9_r[l]  <= p_rnd[l][35:0];
        hk9_r[l] <= hk8_r[l];
        hn9_r[l] <= hn8_r[l];
      end
      m2d9_r <= m2d8_r;
    end
  end

  // stage 10: 1D gradient scale and sign, corner sum
  logic signed [42:0] sum10_r;
  logic               m2d10_r;
  logic signed [40:0] pk [NLANE];
  logic signed [42:0] sum_nxt;

  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      pk[l] = p9_r[l] * $signed({1'b0, hk9_r[l]});
      if (hn9_r[l]) begin
        pk[l] = -pk[l];
      end
    end
    if (m2d9_r) begin
      sum_nxt = 43'(p9_r[0]) + 43'(p9_r[1]) + 43'(p9_r[2]);
    end else begin
      sum_nxt = 43'(pk[0]) + 43'(pk[1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[10]) begin
      sum10_r <= sum_nxt;
      m2d10_r <= m2d9_r;
    end
  end

  // stage 11: clamp far outside the output range, then scale
  localparam logic signed [42:0] SUM_LIM = 43'sd4294967296;
  logic signed [56:0] prod11_r;
  logic signed [33:0] sc;

  always_comb begin
    if (sum10_r > SUM_LIM) begin
      sc = SUM_LIM[33:0];
    end else if (sum10_r < -SUM_LIM) begin
      sc = -(SUM_LIM[33:0]);
    end else begin
      sc = sum10_r[33:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[11]) begin
      prod11_r <= sc * (m2d10_r ? K2D_Q16 : K1D_Q16);
    end
  end

  // stage 12: round to Q16, saturate, output register
  logic signed [17:0]   nv12_r;
  logic signed [PW-1:0] r_rnd;
  logic signed [27:0]   r28;

  always_comb begin
    r_rnd = rnd_q30(PW'(prod11_r));
    r28   = r_rnd[27:0];
  end

  always_ff @(posedge clk) begin
    if (rdy[12]) begin
      if (r28 > 28'(OUT_MAX)) begin
        nv12_r <= OUT_MAX;
      end else if (r28 < -28'(OUT_MAX)) begin
        nv12_r <= -OUT_MAX;
      end else begin
        nv12_r <= r28[17:0];
      end
    end
  end

  assign out_valid       = vld_r[12];
  assign out_noise_value = nv12_r;

endmodule

[rtl/snoise_chk.sv]
module snoise_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic signed [17:0]  out_noise_value
);
  import snoise_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_noise_value))
    else $error("result beat changed while stalled");

  // results stay within plus or minus one
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_noise_value <= OUT_MAX) && (out_noise_value >= -OUT_MAX))
    else $error("noise value out of range");

  // an open output keeps the whole pipe moving
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output is ready");

  // reset empties the pipe
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat right after reset");

endmodule

bind simplex_noise_1d_2d_core snoise_chk u_snoise_chk (.*);
